[rtl/irpdd_pkg.sv]
`default_nettype none
package irpdd_pkg;

  localparam int CODE_BITS = 32;
  localparam logic [15:0] WRAP_ADD = 16'd59999;

  localparam logic [5:0] PHASE_IDLE     = 6'd0;
  localparam logic [5:0] PHASE_FIRST    = 6'd1;
  localparam logic [5:0] PHASE_LAST     = 6'(CODE_BITS);
  localparam logic [5:0] PHASE_RPT_WAIT = 6'd63;

  localparam logic [15:0] GAP_A_MIN = 16'd4000;
  localparam logic [15:0] GAP_A_MAX = 16'd4050;
  localparam logic [15:0] GAP_B_MIN = 16'd9550;
  localparam logic [15:0] GAP_B_MAX = 16'd9620;

  localparam logic EVT_FULL   = 1'b0;
  localparam logic EVT_REPEAT = 1'b1;

  localparam logic [3:0] REG_LEADER_MIN = 4'd0;
  localparam logic [3:0] REG_LEADER_MAX = 4'd1;
  localparam logic [3:0] REG_ZERO_MIN   = 4'd2;
  localparam logic [3:0] REG_ZERO_MAX   = 4'd3;
  localparam logic [3:0] REG_ONE_MIN    = 4'd4;
  localparam logic [3:0] REG_ONE_MAX    = 4'd5;
  localparam logic [3:0] REG_REPEAT_MIN = 4'd6;
  localparam logic [3:0] REG_REPEAT_MAX = 4'd7;

  typedef struct packed {
    logic [15:0] leader_min;
    logic [15:0] leader_max;
    logic [15:0] zero_min;
    logic [15:0] zero_max;
    logic [15:0] one_min;
    logic [15:0] one_max;
    logic [15:0] repeat_min;
    logic [15:0] repeat_max;
  } win_cfg_t;

  typedef struct packed {
    logic leader;
    logic gap;
    logic zero;
    logic one;
    logic rpt;
  } match_t;

  typedef struct packed {
    logic [5:0] phase;
    logic       repeat_allowed;
  } frame_status_t;

endpackage
`default_nettype wire

[rtl/irpdd_cfg.sv]
`default_nettype none
module irpdd_cfg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [3:0]          wr_index,
  input  wire logic [15:0]         wr_data,
  output irpdd_pkg::win_cfg_t      cfg
);
  import irpdd_pkg::*;

  win_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.leader_min <= 16'd1336;
      regs.leader_max <= 16'd1344;
      regs.zero_min   <= 16'd100;
      regs.zero_max   <= 16'd120;
      regs.one_min    <= 16'd210;
      regs.one_max    <= 16'd235;
      regs.repeat_min <= 16'd1110;
      regs.repeat_max <= 16'd1130;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LEADER_MIN: regs.leader_min <= wr_data;
        REG_LEADER_MAX: regs.leader_max <= wr_data;
        REG_ZERO_MIN:   regs.zero_min   <= wr_data;
        REG_ZERO_MAX:   regs.zero_max   <= wr_data;
        REG_ONE_MIN:    regs.one_min    <= wr_data;
        REG_ONE_MAX:    regs.one_max    <= wr_data;
        REG_REPEAT_MIN: regs.repeat_min <= wr_data;
        REG_REPEAT_MAX: regs.repeat_max <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

[rtl/irpdd_classify.sv]
`default_nettype none
module irpdd_classify (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [15:0]         edge_time,
  input  irpdd_pkg::win_cfg_t      cfg,
  output irpdd_pkg::match_t        match
);
  import irpdd_pkg::*;

  logic [15:0] prev_edge_time;
  logic [15:0] interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_edge_time <= '0;
    end else if (step) begin
      prev_edge_time <= edge_time;
    end
  end

  always_comb begin
    if (edge_time > prev_edge_time) begin
      interval = edge_time - prev_edge_time;
    end else begin
      interval = edge_time + WRAP_ADD - prev_edge_time;
    end
  end

  always_comb begin
    match.leader = (cfg.leader_min <= interval) && (interval <= cfg.leader_max);
    match.gap    = ((GAP_A_MIN <= interval) && (interval <= GAP_A_MAX)) ||
                   ((GAP_B_MIN <= interval) && (interval <= GAP_B_MAX));
    match.zero   = (cfg.zero_min <= interval) && (interval <= cfg.zero_max);
    match.one    = (cfg.one_min <= interval) && (interval <= cfg.one_max);
    match.rpt    = (cfg.repeat_min <= interval) && (interval <= cfg.repeat_max);
  end

endmodule
`default_nettype wire

[rtl/irpdd_frame.sv]
`default_nettype none
module irpdd_frame (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  irpdd_pkg::match_t         match,
  output logic                      emit,
  output logic                      kind,
  output logic [31:0]               code,
  output irpdd_pkg::frame_status_t  status
);
  import irpdd_pkg::*;

  logic [5:0]  phase;
  logic [5:0]  phase_next;
  logic [31:0] code_shift;
  logic [31:0] code_shift_next;
  logic        repeat_allowed;
  logic        repeat_allowed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_IDLE;
      code_shift     <= '0;
      repeat_allowed <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      code_shift     <= code_shift_next;
      repeat_allowed <= repeat_allowed_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    code_shift_next     = code_shift;
    repeat_allowed_next = repeat_allowed;
    emit                = 1'b0;
    kind                = EVT_FULL;
    if (phase == PHASE_IDLE) begin
      if (match.leader) begin
        phase_next          = PHASE_FIRST;
        code_shift_next     = '0;
        repeat_allowed_next = 1'b0;
      end else if (repeat_allowed && match.gap) begin
        phase_next = PHASE_RPT_WAIT;
      end
    end else if (phase >= PHASE_FIRST && phase <= PHASE_LAST) begin
      if (match.zero || match.one) begin
        code_shift_next = {code_shift[30:0], !match.zero};
        if (phase == PHASE_LAST) begin
          phase_next          = PHASE_IDLE;
          repeat_allowed_next = 1'b1;
          emit                = 1'b1;
          kind                = EVT_FULL;
        end else begin
          phase_next = phase + 6'd1;
        end
      end else begin
        phase_next = PHASE_IDLE;
      end
    end else if (phase == PHASE_RPT_WAIT) begin
      phase_next = PHASE_IDLE;
      if (match.rpt) begin
        emit = 1'b1;
        kind = EVT_REPEAT;
      end
    end else begin
      phase_next = PHASE_IDLE;
    end
  end

  assign code                  = code_shift_next;
  assign status.phase          = phase;
  assign status.repeat_allowed = repeat_allowed;

endmodule
`default_nettype wire

[rtl/ir_pulse_distance_decoder.sv]
// Pulse-distance infrared remote decoder.
// Input channel (in_valid / in_stall / edge_time): one timer capture per
// falling edge of the receiver. The block forms the interval to the previous
// capture and tracks leader, 32 data bits and repeat frames.
// Output channel (out_valid / out_stall / event_kind / code_word): one item per
// completed frame (event_kind 0) or per accepted repeat (event_kind 1); both
// carry the last assembled code, first bit in the MSB.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): eight
// 16-bit window bounds; cfg_ready is always high, unknown indexes are dropped.
// Flow: an accepted item waits in the input register, is decoded as it steps
// into the result register, and is presented on the output from then on.
// Throughput: one item per cycle unless out_stall holds a result; set by the
// input register feeding the single decode step into the result register.
// Reset (rst, synchronous): windows return to their defaults, the decoder
// goes idle awaiting a leader, the previous capture becomes zero.
// While out_stall holds a result, the input register still takes one item;
// then in_stall rises until the result is taken.
`default_nettype none
module ir_pulse_distance_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] edge_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             event_kind,
  output logic [31:0]      code_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import irpdd_pkg::*;

  win_cfg_t      cfg;
  match_t        match;
  frame_status_t status;

  logic        s1_valid;
  logic [15:0] s1_time;
  logic        advance;
  logic        step;
  logic        emit;
  logic        kind;
  logic [31:0] code;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign step      = s1_valid && advance;
  assign in_stall  = s1_valid && !advance;

  irpdd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  irpdd_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .edge_time (s1_time),
    .cfg       (cfg),
    .match     (match)
  );

  irpdd_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .match  (match),
    .emit   (emit),
    .kind   (kind),
    .code   (code),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_time <= edge_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      event_kind <= kind;
      code_word  <= code;
    end
  end

`ifndef SYNTHESIS
  a_repeat_needs_frame: assert property (@(posedge clk) disable iff (rst)
    (step && emit && kind == EVT_REPEAT) |-> status.repeat_allowed)
    else $error("repeat event without a completed frame");

  a_full_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (step && emit && kind == EVT_FULL) |=> (status.phase == PHASE_IDLE) &&
      status.repeat_allowed)
    else $error("frame end did not return to idle with repeat allowed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room downstream");

  a_leader_clears_flag: assert property (@(posedge clk) disable iff (rst)
    (step && status.phase == PHASE_IDLE && match.leader) |=>
      (status.phase == PHASE_FIRST) && !status.repeat_allowed)
    else $error("leader did not start a frame");
`endif

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
  import irpdd_pkg::*;

  localparam int TIMER_TICKS = 60000;
  localparam int MAX_IV = int'(WRAP_ADD);

  typedef struct packed {
    logic        kind;
    logic [31:0] code;
  } ir_event_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] data;
  } reg_write_t;

  localparam win_cfg_t RESET_WINDOWS = '{
    leader_min: 16'd1336, leader_max: 16'd1344,
    zero_min:   16'd100,  zero_max:   16'd120,
    one_min:    16'd210,  one_max:    16'd235,
    repeat_min: 16'd1110, repeat_max: 16'd1130
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] edge_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        event_kind;
  logic [31:0] code_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ir_pulse_distance_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .edge_time  (edge_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .code_word  (code_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // decoder shadow state
  win_cfg_t    win;
  logic [15:0] prev_capture;
  logic [5:0]  phase;
  logic [31:0] code_shift;
  logic        repeat_ok;
  ir_event_t   pending_events[$];

  // stimulus bookkeeping
  win_cfg_t    stim_win;
  logic [15:0] last_capture = '0;
  bit          idle_on = 1'b1;
  int          captures_sent = 0;
  int          codes_seen = 0;
  int          repeats_seen = 0;
  int          settings_used = 0;
  int          mismatches = 0;
  int          stall_left = 0;

  function automatic bit in_win(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
    return lo <= v && v <= hi;
  endfunction

  task automatic apply_reg(input logic [3:0] idx, input logic [15:0] data);
    case (idx)
      REG_LEADER_MIN: win.leader_min = data;
      REG_LEADER_MAX: win.leader_max = data;
      REG_ZERO_MIN:   win.zero_min = data;
      REG_ZERO_MAX:   win.zero_max = data;
      REG_ONE_MIN:    win.one_min = data;
      REG_ONE_MAX:    win.one_max = data;
      REG_REPEAT_MIN: win.repeat_min = data;
      REG_REPEAT_MAX: win.repeat_max = data;
      default: ;
    endcase
  endtask

  task automatic decode_edge(input logic [15:0] t);
    logic [15:0] iv;
    logic        b;
    if (t > prev_capture) iv = t - prev_capture;
    else iv = t + WRAP_ADD - prev_capture;
    prev_capture = t;
    if (phase == PHASE_IDLE) begin
      if (in_win(iv, win.leader_min, win.leader_max)) begin
        phase = PHASE_FIRST;
        code_shift = '0;
        repeat_ok = 1'b0;
      end else if (repeat_ok && (in_win(iv, GAP_A_MIN, GAP_A_MAX) ||
                                 in_win(iv, GAP_B_MIN, GAP_B_MAX))) begin
        phase = PHASE_RPT_WAIT;
      end
    end else if (phase >= PHASE_FIRST && phase <= PHASE_LAST) begin
      if (in_win(iv, win.zero_min, win.zero_max)) begin
        b = 1'b0;
      end else if (in_win(iv, win.one_min, win.one_max)) begin
        b = 1'b1;
      end else begin
        phase = PHASE_IDLE;
        return;
      end
      code_shift = {code_shift[30:0], b};
      if (phase == PHASE_LAST) begin
        phase = PHASE_IDLE;
        repeat_ok = 1'b1;
        pending_events.push_back('{kind: EVT_FULL, code: code_shift});
      end else begin
        phase = phase + 6'd1;
      end
    end else if (phase == PHASE_RPT_WAIT) begin
      phase = PHASE_IDLE;
      if (in_win(iv, win.repeat_min, win.repeat_max))
        pending_events.push_back('{kind: EVT_REPEAT, code: code_shift});
    end else begin
      phase = PHASE_IDLE;
    end
  endtask

  always @(posedge clk) begin : check_events
    ir_event_t want;
    if (rst) begin
      win = RESET_WINDOWS;
      prev_capture = '0;
      phase = PHASE_IDLE;
      code_shift = '0;
      repeat_ok = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual kind %0d code %h",
                   $time, event_kind, code_word);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (event_kind !== want.kind) begin
            $display("%0t: event_kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, event_kind);
            mismatches++;
          end
          if (code_word !== want.code) begin
            $display("%0t: code_word mismatch, expected %h, actual %h",
                     $time, want.code, code_word);
            mismatches++;
          end
          if (want.kind == EVT_REPEAT) repeats_seen++;
          else codes_seen++;
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) decode_edge(edge_time);
    end
  end

  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_capture(input logic [15:0] t);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    edge_time <= t;
    do @(posedge clk); while (in_stall);
    last_capture = t;
    captures_sent++;
  endtask

  task automatic send_interval(input int iv);
    int t;
    if (int'(last_capture) + iv < TIMER_TICKS) t = int'(last_capture) + iv;
    else t = int'(last_capture) + iv - MAX_IV;
    send_capture(16'(t));
  endtask

  function automatic int pick(logic [15:0] lo, logic [15:0] hi);
    return $urandom_range(int'(hi), int'(lo));
  endfunction

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_events.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input reg_write_t wr[$]);
    cfg_valid <= 1'b1;
    foreach (wr[i]) begin
      cfg_index <= wr[i].idx;
      cfg_data <= wr[i].data;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_windows(input win_cfg_t w);
    reg_write_t wr[$];
    wr.push_back('{REG_LEADER_MIN, w.leader_min});
    wr.push_back('{REG_LEADER_MAX, w.leader_max});
    wr.push_back('{REG_ZERO_MIN, w.zero_min});
    wr.push_back('{REG_ZERO_MAX, w.zero_max});
    wr.push_back('{REG_ONE_MIN, w.one_min});
    wr.push_back('{REG_ONE_MAX, w.one_max});
    wr.push_back('{REG_REPEAT_MIN, w.repeat_min});
    wr.push_back('{REG_REPEAT_MAX, w.repeat_max});
    quiesce();
    write_regs(wr);
    stim_win = w;
    settings_used++;
  endtask

  function automatic win_cfg_t random_windows();
    win_cfg_t w;
    w.zero_min = 16'($urandom_range(20, 300));
    w.zero_max = w.zero_min + 16'($urandom_range(0, 40));
    w.one_min = w.zero_max + 16'($urandom_range(1, 100));
    w.one_max = w.one_min + 16'($urandom_range(0, 40));
    w.repeat_min = 16'($urandom_range(600, 1500));
    w.repeat_max = w.repeat_min + 16'($urandom_range(0, 60));
    w.leader_min = 16'($urandom_range(1600, 3800));
    w.leader_max = w.leader_min + 16'($urandom_range(0, 60));
    return w;
  endfunction

  // break_at < 0 sends the whole frame
  task automatic send_frame(input logic [31:0] code, input int break_at);
    send_interval(pick(stim_win.leader_min, stim_win.leader_max));
    for (int i = 31; i >= 0; i--) begin
      if (i == break_at) begin
        send_interval($urandom_range(1, MAX_IV));
        return;
      end
      if (code[i]) send_interval(pick(stim_win.one_min, stim_win.one_max));
      else send_interval(pick(stim_win.zero_min, stim_win.zero_max));
    end
  endtask

  task automatic send_repeats();
    int n;
    int r;
    n = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_interval($urandom_range(1, MAX_IV));
      else if (r < 5) send_interval(pick(GAP_A_MIN, GAP_A_MAX));
      else send_interval(pick(GAP_B_MIN, GAP_B_MAX));
      r = $urandom_range(0, 9);
      if (r == 0) send_interval(pick(stim_win.leader_min, stim_win.leader_max));
      else if (r == 1) send_interval(int'(stim_win.repeat_max) + 1);
      else send_interval(pick(stim_win.repeat_min, stim_win.repeat_max));
    end
  endtask

  task automatic test_default_windows();
    logic [31:0] code;
    stim_win = RESET_WINDOWS;
    settings_used++;
    code = 32'hA5C3_0FF1;
    send_interval(1336);
    for (int i = 31; i >= 0; i--) begin
      if (code[i]) send_interval((i % 2) ? 235 : 210);
      else send_interval((i % 2) ? 120 : 100);
    end
    send_interval(int'(GAP_A_MIN));
    send_interval(1110);
    send_interval(int'(GAP_B_MAX));
    send_interval(1130);
    // leader during the repeat wait is not taken
    send_interval(int'(GAP_A_MAX));
    send_interval(1340);
    send_interval(int'(GAP_B_MIN));
    send_interval(1109);
    // abort on a bad bit
    send_interval(1344);
    send_interval(99);
    send_capture(last_capture);
    send_capture(16'hFFFF);
    send_capture(16'(TIMER_TICKS));
    send_capture(16'h0000);
  endtask

  task automatic test_stray_index();
    reg_write_t wr[$];
    for (int k = int'(REG_REPEAT_MAX) + 1; k < 16; k++)
      wr.push_back('{4'(k), 16'($urandom)});
    quiesce();
    write_regs(wr);
    send_frame($urandom, -1);
    send_interval(int'(GAP_A_MIN) + 10);
    send_interval(1120);
  endtask

  task automatic test_window_extremes();
    win_cfg_t w;
    w = '{default: 16'h0000};
    w.leader_min = 16'hFFFF;
    w.zero_min = 16'hFFFF;
    w.one_min = 16'hFFFF;
    w.repeat_min = 16'hFFFF;
    load_windows(w);
    repeat (12) send_capture(16'($urandom_range(0, 65535)));

    w = '{default: 16'hFFFF};
    w.leader_min = 16'h0000;
    w.zero_min = 16'h0000;
    w.one_min = 16'h0000;
    w.repeat_min = 16'h0000;
    load_windows(w);
    repeat (40) send_capture(16'($urandom_range(0, 65535)));

    // zero window overlaps the one window and wins
    w = RESET_WINDOWS;
    w.zero_min = 16'd100;
    w.zero_max = 16'd200;
    w.one_min = 16'd150;
    w.one_max = 16'd250;
    w.repeat_min = 16'h0000;
    w.repeat_max = 16'hFFFF;
    load_windows(w);
    send_interval(1340);
    for (int i = 0; i < 32; i++) begin
      case (i % 4)
        0: send_interval(150);
        1: send_interval(200);
        2: send_interval(201);
        default: send_interval(250);
      endcase
    end
    send_interval(int'(GAP_A_MIN));
    send_interval(1);
    send_interval(9600);
    send_capture(last_capture);
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop;
    int r;
    stop = captures_sent + n_items;
    while (captures_sent < stop) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 4)) send_capture(16'($urandom_range(0, 65535)));
      end else if (r == 1) begin
        send_frame($urandom, $urandom_range(0, 31));
      end else if (r == 2) begin
        send_frame($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000, -1);
        send_repeats();
      end else begin
        send_frame($urandom, -1);
        send_repeats();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_default_windows();
    test_stray_index();
    test_window_extremes();
    load_windows(RESET_WINDOWS);
    test_random_traffic(300);
    load_windows(random_windows());
    test_random_traffic(300);
    load_windows(random_windows());
    test_random_traffic(300);
    load_windows(random_windows());
    idle_on = 1'b0;
    test_random_traffic(250);
    quiesce();
    repeat (8) @(posedge clk);
    $display("Run covered %0d captures over %0d window settings,", captures_sent,
             settings_used);
    $display("with %0d full codes and %0d repeat events checked.", codes_seen,
             repeats_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
